### hw/rtl/xkc_pkg.sv
// Package for the xorshift keystream cipher unit: constants, shared types
// and the arithmetic helpers used by the seed unit and the keystream logic.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package xkc_pkg;

  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [63:0] FNV_BASIS      = 64'hcbf29ce484222325;
  // The FNV prime is 2^40 + 0x1b3, so a multiply is one shift and a narrow product.
  localparam int unsigned FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
  localparam logic [63:0] ZERO_SEED_FILL = 64'h5A5A5A5A5A5A5A5A;

  localparam int unsigned XS_SHIFT_A = 13;
  localparam int unsigned XS_SHIFT_B = 7;
  localparam int unsigned XS_SHIFT_C = 17;

  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_1  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_2  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_3  = 3'd4;

  typedef logic [KEY_WORDS-1:0][63:0] key_words_t;

  typedef struct packed {
    logic       enable;
    key_words_t key;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seed_stat_t;

  // Product modulo 2^64 with the FNV prime.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [72:0] lo;
    lo = x * FNV_PRIME_LO;
    return (x << FNV_PRIME_SHIFT) + lo[63:0];
  endfunction

  function automatic logic [63:0] xorshift64(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    a = x ^ (x << XS_SHIFT_A);
    b = a ^ (a >> XS_SHIFT_B);
    return b ^ (b << XS_SHIFT_C);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/xkc_if.sv
// Stream interfaces of the cipher unit: the byte input channel and the
// result channel, each with valid, ready and payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xkc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [63:0] nonce;

  modport source (output valid, data_byte, first_byte, last_byte, nonce, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, nonce, output ready);
endinterface

interface xkc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/xorshift_keystream_xor_cipher_unit.sv
// Top level of the xorshift keystream cipher: one byte per cycle while the result
// slot is free, except that a first byte with the cipher enabled waits for the
// seed unit, which runs one FNV step per cycle over KEY_BYTES key bytes and the
// nonce plus a fixup; that byte's result is registered once the seed is done.
// Other bytes give a result in the cycle after acceptance, back to back.
// Reset (synchronous, rst_n low) clears the generator word, position and valids.
`timescale 1ns / 1ps
`default_nettype none

module xorshift_keystream_xor_cipher_unit #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  xkc_in_if.sink           in_if,
  xkc_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import xkc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEED = 2'b10
  } state_t;

  cfg_t       cfg;
  seed_stat_t seed_stat;
  logic [63:0] seed;

  state_t      state_r, state_nxt;
  logic [63:0] gen_r, gen_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [7:0]  hold_byte_r;
  logic        hold_last_r;

  logic        slot_free, accept, seed_start, emit_direct, emit_seed, emit;
  logic        in_ready, apply;
  logic [63:0] base_gen, adv_gen, cur_word;
  logic [2:0]  base_pos;
  logic [7:0]  ks_byte, data_sel;
  logic        last_sel;

  xkc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xkc_seed_unit #(.KEY_BYTES(KEY_BYTES)) u_seed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_start),
    .nonce (in_if.nonce),
    .key   (cfg.key),
    .seed  (seed),
    .stat  (seed_stat)
  );

  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_ready    = (state_r == S_IDLE) && slot_free;
  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;
  assign seed_start  = accept && cfg.enable && in_if.first_byte;
  assign emit_direct = accept && !seed_start;
  assign emit_seed   = (state_r == S_SEED) && seed_stat.done && slot_free;
  assign emit        = emit_direct || emit_seed;

  // A freshly seeded message starts at byte position zero of the new word.
  assign base_gen = (state_r == S_SEED) ? seed : gen_r;
  assign base_pos = (state_r == S_SEED) ? 3'd0 : pos_r;
  assign adv_gen  = xorshift64(base_gen);
  assign cur_word = (base_pos == 3'd0) ? adv_gen : base_gen;
  assign ks_byte  = cur_word[{base_pos, 3'b000} +: 8];
  assign data_sel = (state_r == S_SEED) ? hold_byte_r : in_if.data_byte;
  assign last_sel = (state_r == S_SEED) ? hold_last_r : in_if.last_byte;
  assign apply    = (state_r == S_SEED) || cfg.enable;

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (seed_start) begin
      state_nxt = S_SEED;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = last_sel;
      out_byte_nxt  = apply ? (data_sel ^ ks_byte) : data_sel;
      if (apply) begin
        gen_nxt = cur_word;
        pos_nxt = base_pos + 3'd1;
      end
      if (emit_seed) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (seed_start) begin
      hold_byte_r <= in_if.data_byte;
      hold_last_r <= in_if.last_byte;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.out_last = out_last_r;

  a_no_accept_while_seeding: assert property (@(posedge clk) disable iff (!rst_n)
    seed_stat.busy |-> !in_ready)
    else $error("input accepted while the seed unit is busy");

  a_seed_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    seed_start |=> (state_r == S_SEED) && !out_valid_r || (state_r == S_SEED))
    else $error("seeded transaction did not enter the seed wait state");

  a_seed_emit_position: assert property (@(posedge clk) disable iff (!rst_n)
    emit_seed |=> (pos_r == 3'd1) && out_valid_r)
    else $error("seeded byte did not restart the byte position");

  a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit_direct && emit_seed))
    else $error("two results produced in one cycle");

endmodule

`default_nettype wire

### hw/rtl/xkc_cfg_regs.sv
// APB-style register block: enable bit and four 64-bit key words at 8-byte
// spacing. Depends on xkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xkc_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output xkc_pkg::cfg_t     cfg
);
  import xkc_pkg::*;

  logic                 enable_r;
  key_words_t           key_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      key_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE: enable_r <= pwdata[0];
        REG_KEY_0:  key_r[0] <= pwdata;
        REG_KEY_1:  key_r[1] <= pwdata;
        REG_KEY_2:  key_r[2] <= pwdata;
        REG_KEY_3:  key_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE: prdata = {63'd0, enable_r};
      REG_KEY_0:  prdata = key_r[0];
      REG_KEY_1:  prdata = key_r[1];
      REG_KEY_2:  prdata = key_r[2];
      REG_KEY_3:  prdata = key_r[3];
      default:    prdata = '0;
    endcase
  end

  assign cfg.enable = enable_r;
  assign cfg.key    = key_r;

endmodule

`default_nettype wire

### hw/rtl/xkc_seed_unit.sv
// Seed sequencer: one shared FNV-1a step unit iterated over the key bytes
// and the nonce, then a zero-seed fixup. Depends on xkc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xkc_seed_unit #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [63:0]         nonce,
  input  wire xkc_pkg::key_words_t key,
  output logic [63:0]              seed,
  output xkc_pkg::seed_stat_t      stat
);
  import xkc_pkg::*;

  localparam int unsigned CW = $clog2(KEY_BYTES + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(KEY_BYTES);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_HASH = 4'b0010,
    U_FIX  = 4'b0100,
    U_DONE = 4'b1000
  } ustate_t;

  ustate_t     state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] nonce_r;
  logic [CW+4:0] cnt_ext;
  logic [4:0]  key_idx;
  logic [7:0]  key_byte;
  logic [63:0] operand;

  assign cnt_ext  = {5'd0, cnt_r};
  assign key_idx  = cnt_ext[4:0];
  assign key_byte = key[key_idx[4:3]][{key_idx[2:0], 3'b000} +: 8];
  // The key bytes come first; the step after the last key byte mixes in the nonce.
  assign operand  = (cnt_r == LAST_STEP) ? nonce_r : {56'd0, key_byte};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    h_nxt     = h_r;
    if (start) begin
      state_nxt = U_HASH;
      cnt_nxt   = '0;
      h_nxt     = FNV_BASIS;
    end else begin
      case (state_r)
        U_HASH: begin
          h_nxt   = fnv_mul(h_r ^ operand);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            state_nxt = U_FIX;
          end
        end
        U_FIX: begin
          if (h_r == '0) begin
            h_nxt = ZERO_SEED_FILL;
          end
          state_nxt = U_DONE;
        end
        U_IDLE, U_DONE: ;
        default: state_nxt = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    if (start) begin
      nonce_r <= nonce;
    end
  end

  assign seed      = h_r;
  assign stat.busy = (state_r == U_HASH) || (state_r == U_FIX);
  assign stat.done = (state_r == U_DONE);

endmodule

`default_nettype wire

### tb/sv/xorshift_keystream_xor_cipher_unit_tb.sv
// Self-checking testbench for the xorshift keystream cipher unit: a scoreboard
// class predicts every output byte, plain tasks drive the byte stream and APB port.
// Depends on xkc_pkg and the xkc_in_if / xkc_out_if stream interfaces.
`timescale 1ns / 1ps

module xorshift_keystream_xor_cipher_unit_tb;
  import xkc_pkg::*;

  localparam int unsigned KEY_LEN     = 16;
  localparam logic [63:0] FNV_MULT    = 64'h100000001b3;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned GUARD       = KEY_LEN + 8;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_REPORTS = 200;
  localparam int unsigned PHASE_ITEMS = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  class cipher_scoreboard;
    logic        enabled;
    logic [63:0] key_words[KEY_WORDS];
    logic [63:0] stream_word;
    logic [2:0]  lane;
    cipher_out_t bytes_due[$];
    int unsigned failures;

    function new();
      enabled = 1'b0;
      foreach (key_words[i]) key_words[i] = '0;
      stream_word = '0;
      lane = '0;
      failures = 0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_ENABLE: enabled = val[0];
        REG_KEY_0:  key_words[0] = val;
        REG_KEY_1:  key_words[1] = val;
        REG_KEY_2:  key_words[2] = val;
        REG_KEY_3:  key_words[3] = val;
        default: ;
      endcase
    endfunction

    // FNV-1a over the key bytes only, before the nonce is folded in.
    function logic [63:0] key_hash();
      logic [63:0] h;
      h = FNV_BASIS;
      for (int i = 0; i < KEY_LEN && i < 32; i++) begin
        h = h ^ ((key_words[i / 8] >> (8 * (i % 8))) & 64'hFF);
        h = h * FNV_MULT;
      end
      return h;
    endfunction

    function logic [63:0] next_word(logic [63:0] x);
      x = x ^ (x << XS_SHIFT_A);
      x = x ^ (x >> XS_SHIFT_B);
      x = x ^ (x << XS_SHIFT_C);
      return x;
    endfunction

    function void take_input(logic [7:0] d, logic f, logic l, logic [63:0] n);
      cipher_out_t r;
      logic [63:0] seed;
      r.data = d;
      r.last = l;
      if (enabled) begin
        if (f) begin
          seed = (key_hash() ^ n) * FNV_MULT;
          stream_word = (seed == '0) ? ZERO_SEED_FILL : seed;
          lane = '0;
        end
        if (lane == 3'd0) stream_word = next_word(stream_word);
        r.data = d ^ stream_word[{lane, 3'b000} +: 8];
        lane = lane + 3'd1;
      end
      bytes_due.push_back(r);
    endfunction

    function void check_output(logic [7:0] got_data, logic got_last);
      cipher_out_t r;
      if (bytes_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected output byte %02h last %0b, expected none",
                   $time, got_data, got_last);
        return;
      end
      r = bytes_due.pop_front();
      if (got_data !== r.data) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: out_byte expected %02h actual %02h", $time, r.data, got_data);
      end
      if (got_last !== r.last) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: out_last expected %0b actual %0b", $time, r.last, got_last);
      end
    endfunction

    function int unsigned outstanding();
      return bytes_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  xkc_in_if  in_ch();
  xkc_out_if out_ch();

  cipher_scoreboard sb;
  int unsigned      hold_off_seq = 0;
  int unsigned      burst_left = 0;
  bit               gaps_on = 1'b1;

  xorshift_keystream_xor_cipher_unit #(
    .KEY_BYTES(KEY_LEN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Both channels are sampled at the edge with the values held during the cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.take_input(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte, in_ch.nonce);
      if (out_ch.valid && out_ch.ready)
        sb.check_output(out_ch.out_byte, out_ch.out_last);
    end
  end

  // Result side: cycles through full-rate, random and periodic stall styles, and
  // drops ready for a long stretch whenever the stimulus asks for a hold-off.
  initial begin : result_sink
    int unsigned holds_done;
    int unsigned cyc;
    int unsigned style;
    holds_done = 0;
    cyc = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_seq != holds_done) begin
        holds_done = hold_off_seq;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        style = (cyc / 97) % 4;
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(1, 0) == 1);
          2: out_ch.ready <= (cyc % 3 == 0);
          default: out_ch.ready <= ($urandom_range(9, 0) < 8);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic en, input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3);
    reg_write(REG_ENABLE, {63'd0, en});
    reg_write(REG_KEY_0, k0);
    reg_write(REG_KEY_1, k1);
    reg_write(REG_KEY_2, k2);
    reg_write(REG_KEY_3, k3);
  endtask

  // Offers one byte and returns at the edge where the transaction is accepted.
  task automatic push_byte(input logic [7:0] d, input logic f, input logic l,
                           input logic [63:0] n);
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      if (gaps_on && $urandom_range(9, 0) < 7) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.first_byte <= f;
    in_ch.last_byte  <= l;
    in_ch.nonce      <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Waits on falling edges so the check never races the monitor's pops.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
    repeat (GUARD) @(posedge clk);
  endtask

  task automatic run_traffic(input int unsigned count, input bit with_hold);
    int unsigned sent;
    int unsigned len;
    bit          tidy;
    bit          held;
    logic [63:0] msg_nonce;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      if (with_hold && !held && sent >= 40) begin
        hold_off_seq <= hold_off_seq + 1;
        held = 1'b1;
      end
      len  = ($urandom_range(4, 0) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 1);
      tidy = ($urandom_range(6, 0) != 0);
      // Now and then pick the nonce that cancels the key hash to force a zero seed.
      msg_nonce = ($urandom_range(39, 0) == 0) ? sb.key_hash() : rand64();
      for (int i = 0; i < len; i++) begin
        if (tidy)
          push_byte(8'($urandom_range(255, 0)), i == 0, i == len - 1,
                    (i == 0) ? msg_nonce : rand64());
        else
          push_byte(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0,
                    $urandom_range(3, 0) == 0, rand64());
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    sb = new();
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    in_ch.nonce      <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: bytes pass through and a first byte does not reseed.
    push_byte(8'h00, 1'b1, 1'b1, '1);
    push_byte(8'hFF, 1'b1, 1'b0, '0);
    drain();

    load_settings(1'b1, '0, '0, '0, '0);
    // No message started yet, so the generator word is zero and so is the keystream.
    push_byte(8'h00, 1'b0, 1'b0, rand64());
    push_byte(8'hFF, 1'b0, 1'b0, rand64());
    push_byte(8'hA5, 1'b0, 1'b1, rand64());
    for (int i = 0; i < 9; i++)
      push_byte(i[0] ? 8'hFF : 8'h00, i == 0, i == 8, (i == 0) ? 64'd0 : '1);
    // Bytes after a last byte with no new first byte keep using the current word.
    push_byte(8'h3C, 1'b0, 1'b0, rand64());
    push_byte(8'hC3, 1'b0, 1'b0, rand64());
    push_byte(8'h81, 1'b0, 1'b1, rand64());
    push_byte(8'h5A, 1'b1, 1'b1, '1);
    for (int i = 0; i < 6; i++)
      push_byte(8'hFF - 8'(i), i == 0, i == 5, sb.key_hash());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(1'b1, '1, '1, rand64(), rand64());
        1: load_settings(1'b1, rand64(), rand64(), rand64(), rand64());
        2: load_settings(1'b0, rand64(), rand64(), '0, '1);
        3: load_settings(1'b1, '0, '0, '1, '1);
        4: load_settings(1'b1, rand64(), rand64(), rand64(), rand64());
        default: load_settings(1'b1, rand64(), '1, rand64(), rand64());
      endcase
      gaps_on = (ph != 1);
      run_traffic(PHASE_ITEMS, ph == 0 || ph == 3);
      drain();
    end

    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### xorshift_keystream_xor_cipher_unit.f
hw/rtl/xkc_pkg.sv
hw/rtl/xkc_if.sv
hw/rtl/xkc_cfg_regs.sv
hw/rtl/xkc_seed_unit.sv
hw/rtl/xorshift_keystream_xor_cipher_unit.sv
tb/sv/xorshift_keystream_xor_cipher_unit_tb.sv
